@@ hdl/lz4bd_pkg.sv @@
// shared types and constants of the lz4 block decoder
`timescale 1ns / 1ps
package lz4bd_pkg;

    localparam int CNT_W           = 21;          // decoded_size and output count
    localparam int LEN_W           = CNT_W + 1;   // saturating length accumulator
    localparam int WIN_BYTES       = 65536;
    localparam int WIN_AW          = $clog2(WIN_BYTES);
    localparam int DIST_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int TDATA_W         = 16;
    localparam int MAX_DECODED_DEF = 1048576;

    localparam logic [CNT_W-1:0]  SIZE_RESET = CNT_W'(1048576);
    localparam logic [3:0]        NIB_EXT    = 4'hF;
    localparam logic [BYTE_W-1:0] BYTE_EXT   = 8'hFF;
    localparam int                MIN_MATCH  = 4;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LITEXT,
        PH_LITERAL,
        PH_OFFLO,
        PH_OFFHI,
        PH_MATEXT
    } phase_t;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_TRUNC_LEN,
        ERR_BAD_LIT,
        ERR_TRUNC_OFF,
        ERR_BAD_OFF,
        ERR_BAD_MATCH,
        ERR_INCOMPLETE,
        ERR_EXTRA
    } err_t;

    // per-item result of the parser, carried down the pipeline
    typedef struct packed {
        logic              out_valid;
        logic              is_copy;
        logic [BYTE_W-1:0] lit_byte;
        logic [WIN_AW-1:0] wr_addr;
        logic [WIN_AW-1:0] rd_addr;
        logic              consumed;
        logic              copy_pending;
        logic              done;
        err_t              err;
    } res_t;

endpackage

@@ hdl/lz4bd_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign rdata = q_reg;

endmodule

@@ hdl/lz4bd_ctrl.sv @@
// lz4 sequence parser: phase, lengths, counters, size checks and error tracking
`timescale 1ns / 1ps
module lz4bd_ctrl #(
    parameter int MAX_DECODED_BYTES = lz4bd_pkg::MAX_DECODED_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic                           tick,
    input  logic [lz4bd_pkg::BYTE_W-1:0]   in_byte,
    input  logic                           in_last,
    input  logic                           cfg_valid,
    input  logic [lz4bd_pkg::CNT_W-1:0]    cfg_data,
    output lz4bd_pkg::res_t                res
);

    import lz4bd_pkg::*;

    localparam int MAX_W = $clog2(MAX_DECODED_BYTES + 1);
    localparam int CMP_W = (MAX_W > CNT_W) ? MAX_W : CNT_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DECODED_BYTES);

    phase_t             phase_reg, phase_next;
    logic [3:0]         nib_reg, nib_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [CNT_W-1:0]   oc_reg, oc_next;
    logic [CNT_W-1:0]   copy_reg, copy_next;
    err_t               err_reg, err_next;
    logic               ended_reg, ended_next;
    logic               fin_reg, fin_next;
    logic [CNT_W-1:0]   size_reg;

    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   space;
    logic [LEN_W-1:0]   space_ext;
    logic [CNT_W-1:0]   oc_inc;
    logic [LEN_W:0]     sum_b_wide;
    logic [LEN_W-1:0]   sum_b;
    logic [LEN_W-1:0]   lit_len;
    logic [LEN_W-1:0]   mat_base;
    logic [LEN_W:0]     mat_wide;
    logic [LEN_W-1:0]   mat_len;
    logic [DIST_W-1:0]  dist_full;
    logic               lit_go;
    logic               mat_go;
    logic               live;
    logic               lit_emit;

    // effective size limit and remaining room
    assign lim       = (CMP_W'(size_reg) > MAX_C) ? MAX_C[CNT_W-1:0] : size_reg;
    assign space     = (oc_reg >= lim) ? '0 : lim - oc_reg;
    assign space_ext = LEN_W'(space);
    assign oc_inc    = oc_reg + 1'b1;

    // saturating length sums
    assign sum_b_wide = {1'b0, acc_reg} + (LEN_W+1)'(in_byte);
    assign sum_b      = sum_b_wide[LEN_W] ? '1 : sum_b_wide[LEN_W-1:0];
    assign lit_len    = (phase_reg == PH_TOKEN) ? LEN_W'(in_byte[7:4]) : sum_b;
    assign mat_base   = (phase_reg == PH_OFFHI) ? LEN_W'(nib_reg) : sum_b;
    assign mat_wide   = {1'b0, mat_base} + (LEN_W+1)'(MIN_MATCH);
    assign mat_len    = mat_wide[LEN_W] ? '1 : mat_wide[LEN_W-1:0];
    assign dist_full  = {in_byte, dist_reg[7:0]};

    // next state
    always_comb begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        acc_next   = acc_reg;
        dist_next  = dist_reg;
        oc_next    = oc_reg;
        copy_next  = copy_reg;
        err_next   = err_reg;
        ended_next = ended_reg;
        fin_next   = fin_reg;
        lit_go     = 1'b0;
        mat_go     = 1'b0;

        if (step && err_reg == ERR_OK) begin
            priority if (copy_reg != '0) begin
                oc_next   = oc_inc;
                copy_next = copy_reg - 1'b1;
                if (copy_reg == CNT_W'(1) && ended_reg) begin
                    if (oc_inc == lim) fin_next = 1'b1;
                    else               err_next = ERR_INCOMPLETE;
                end
            end else if (fin_reg) begin
                if (!tick) begin
                    err_next = ERR_EXTRA;
                    fin_next = 1'b0;
                end
            end else if (!tick) begin
                unique case (phase_reg)
                    PH_TOKEN: begin
                        nib_next = in_byte[3:0];
                        acc_next = LEN_W'(in_byte[7:4]);
                        if (in_byte[7:4] == NIB_EXT) begin
                            if (in_last) err_next   = ERR_TRUNC_LEN;
                            else         phase_next = PH_LITEXT;
                        end else begin
                            lit_go = 1'b1;
                        end
                    end
                    PH_LITEXT: begin
                        acc_next = sum_b;
                        if (in_byte == BYTE_EXT) begin
                            if (in_last) err_next = ERR_TRUNC_LEN;
                        end else begin
                            lit_go = 1'b1;
                        end
                    end
                    PH_LITERAL: begin
                        if (acc_reg > LEN_W'(1) && in_last) begin
                            err_next = ERR_BAD_LIT;
                        end else begin
                            oc_next  = oc_inc;
                            acc_next = acc_reg - 1'b1;
                            if (acc_reg == LEN_W'(1)) begin
                                if (in_last) begin
                                    if (oc_inc == lim) fin_next = 1'b1;
                                    else               err_next = ERR_INCOMPLETE;
                                end else begin
                                    phase_next = PH_OFFLO;
                                end
                            end
                        end
                    end
                    PH_OFFLO: begin
                        if (in_last) begin
                            err_next = ERR_TRUNC_OFF;
                        end else begin
                            dist_next  = DIST_W'(in_byte);
                            phase_next = PH_OFFHI;
                        end
                    end
                    PH_OFFHI: begin
                        dist_next = dist_full;
                        if (dist_full == '0 || CNT_W'(dist_full) > oc_reg) begin
                            err_next = ERR_BAD_OFF;
                        end else begin
                            acc_next = LEN_W'(nib_reg);
                            if (nib_reg == NIB_EXT) begin
                                if (in_last) err_next   = ERR_TRUNC_LEN;
                                else         phase_next = PH_MATEXT;
                            end else begin
                                mat_go = 1'b1;
                            end
                        end
                    end
                    PH_MATEXT: begin
                        acc_next = sum_b;
                        if (in_byte == BYTE_EXT) begin
                            if (in_last) err_next = ERR_TRUNC_LEN;
                        end else begin
                            mat_go = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_TOKEN;
                    end
                endcase

                if (lit_go) begin
                    priority if (lit_len > space_ext) begin
                        err_next = ERR_BAD_LIT;
                    end else if (lit_len == '0) begin
                        if (in_last) begin
                            if (oc_reg == lim) fin_next = 1'b1;
                            else               err_next = ERR_INCOMPLETE;
                        end else begin
                            phase_next = PH_OFFLO;
                        end
                    end else if (in_last) begin
                        err_next = ERR_BAD_LIT;
                    end else begin
                        phase_next = PH_LITERAL;
                    end
                end

                if (mat_go) begin
                    if (mat_len > space_ext) begin
                        err_next = ERR_BAD_MATCH;
                    end else begin
                        copy_next  = mat_len[CNT_W-1:0];
                        ended_next = in_last;
                        phase_next = PH_TOKEN;
                    end
                end
            end else begin
                // tick with nothing to drain: state holds
            end
        end
    end

    // per-item outputs
    always_comb begin
        live             = step && err_reg == ERR_OK;
        res.is_copy      = live && copy_reg != '0;
        res.consumed     = live && copy_reg == '0 && !fin_reg && !tick;
        lit_emit         = res.consumed && phase_reg == PH_LITERAL &&
                           !(acc_reg > LEN_W'(1) && in_last);
        res.out_valid    = res.is_copy || lit_emit;
        res.lit_byte     = lit_emit ? in_byte : '0;
        res.wr_addr      = oc_reg[WIN_AW-1:0];
        res.rd_addr      = oc_reg[WIN_AW-1:0] - WIN_AW'(dist_reg);
        res.copy_pending = err_next == ERR_OK && copy_next != '0;
        res.done         = err_next == ERR_OK && fin_next;
        res.err          = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TOKEN;
            nib_reg   <= '0;
            acc_reg   <= '0;
            dist_reg  <= '0;
            oc_reg    <= '0;
            copy_reg  <= '0;
            err_reg   <= ERR_OK;
            ended_reg <= 1'b0;
            fin_reg   <= 1'b0;
            size_reg  <= SIZE_RESET;
        end else begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            acc_reg   <= acc_next;
            dist_reg  <= dist_next;
            oc_reg    <= oc_next;
            copy_reg  <= copy_next;
            err_reg   <= err_next;
            ended_reg <= ended_next;
            fin_reg   <= fin_next;
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
        end
    end

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_OK) |=> $stable(err_reg))
        else $error("error code changed after being set");

    a_copy_in_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (copy_reg != '0) |-> (phase_reg == PH_TOKEN))
        else $error("match copy pending outside token phase");

    a_fin_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> (err_reg == ERR_OK))
        else $error("block finished with an error set");

endmodule

@@ hdl/lz4_block_decoder.sv @@
// lz4 block decoder top level: stream ports, history ram, result pipeline
`timescale 1ns / 1ps
// Streaming LZ4 block decoder. Each input transfer carries one compressed byte or a
// tick and yields exactly one result transfer; a new item is taken every cycle while
// the result side keeps up; results are registered in the match stage, then at the output.
// Match bytes are read from a 64 KiB history ram with one write and one read port;
// the read for a match byte is issued when its item is taken, and the byte written by
// the item just ahead is forwarded when both touch the same entry. The history is not
// cleared after reset (offsets can never reach unwritten entries). decoded_size is
// written through the cfg channel, which is always ready, and must only change while
// no item is in flight.
module lz4_block_decoder #(
    parameter int MAX_DECODED_BYTES = lz4bd_pkg::MAX_DECODED_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lz4bd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  logic                             s_tuser,   // [0] req_type
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lz4bd_pkg::TDATA_W-1:0]    m_tdata,   // [7:0] out_byte, [8] consumed,
                                                        // [9] copy_pending, [10] done_res,
                                                        // [13:11] error_code, [15:14] zero
    output logic                             m_tuser,   // [0] out_valid
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lz4bd_pkg::CNT_W-1:0]      cfg_data
);

    import lz4bd_pkg::*;

    res_t               res;
    logic               accept;
    logic               b_adv;
    logic               b_valid_reg;
    res_t               b_res_reg;
    logic               b_fwd_reg;
    logic [BYTE_W-1:0]  b_fwd_data_reg;
    logic [BYTE_W-1:0]  b_byte;
    logic [BYTE_W-1:0]  ram_q;
    logic               ram_we;
    logic               o_valid_reg, o_valid_next;
    logic [TDATA_W-1:0] o_data_reg;
    logic               o_user_reg;

    assign cfg_ready = 1'b1;
    assign b_adv     = b_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready  = !b_valid_reg || b_adv;
    assign accept    = s_tvalid && s_tready;

    lz4bd_ctrl #(
        .MAX_DECODED_BYTES(MAX_DECODED_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .tick     (s_tuser == REQ_TICK),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .res      (res)
    );

    // match bytes come from the ram unless the entry was being written when the read was issued
    assign b_byte = !b_res_reg.is_copy ? b_res_reg.lit_byte
                                       : (b_fwd_reg ? b_fwd_data_reg : ram_q);
    assign ram_we = b_adv && b_res_reg.out_valid;

    lz4bd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(WIN_BYTES)
    ) u_hist (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(b_res_reg.wr_addr),
        .wdata(b_byte),
        .re   (accept && res.is_copy),
        .raddr(res.rd_addr),
        .rdata(ram_q)
    );

    always_comb begin
        o_valid_next = o_valid_reg;
        if (b_adv) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_res_reg      <= res;
            b_fwd_reg      <= ram_we && res.is_copy && (b_res_reg.wr_addr == res.rd_addr);
            b_fwd_data_reg <= b_byte;
        end
        if (b_adv) begin
            o_data_reg <= {2'b00, b_res_reg.err, b_res_reg.done, b_res_reg.copy_pending,
                           b_res_reg.consumed, b_byte};
            o_user_reg <= b_res_reg.out_valid;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

    a_copy_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.is_copy) |=> (b_valid_reg && b_res_reg.is_copy))
        else $error("match read issued without a copy item in the stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> (b_valid_reg && $stable(b_res_reg.wr_addr)))
        else $error("stalled stage lost its item");

    a_fwd_copy_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_fwd_reg && b_res_reg.out_valid && !b_res_reg.is_copy) |-> 1'b0)
        else $error("forwarding flagged on a literal item");

endmodule
